// File: sv/ttrm_pkg.sv
// shared types, codes and constants of the touch to relative motion block
`default_nettype none
package ttrm_pkg;

	localparam int DEFAULT_POSITION_WIDTH = 16;
	localparam int TOUCH_MIN_RESET        = 1200;
	localparam int DELTA_LIMIT            = 255;
	localparam int DELTA_WIDTH            = 8;
	localparam int DIR_WIDTH              = 2;
	localparam int MODE_WIDTH             = 2;
	localparam int CFG_INDEX_WIDTH        = 2;

	// touch modes
	localparam logic [MODE_WIDTH-1:0] MODE_IDLE     = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_TOUCHING = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_RELEASED = 2'd2;

	// axis directions
	localparam logic [DIR_WIDTH-1:0] DIR_NONE = 2'd0;
	localparam logic [DIR_WIDTH-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_WIDTH-1:0] DIR_DOWN = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_X_TOUCH_MIN = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_Y_TOUCH_MIN = 2'd1;

	typedef struct packed {
		logic                   button;
		logic [DIR_WIDTH-1:0]   x_direction;
		logic [DELTA_WIDTH-1:0] x_delta;
		logic [DIR_WIDTH-1:0]   y_direction;
		logic [DELTA_WIDTH-1:0] y_delta;
	} report_t;

endpackage
`default_nettype wire

// File: sv/ttrm_axis.sv
// direction and saturated magnitude of motion on one axis
`default_nettype none
module ttrm_axis
	import ttrm_pkg::*;
#(
	parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
	input  wire logic [POSITION_WIDTH-1:0] cur,
	input  wire logic [POSITION_WIDTH-1:0] prev,
	output logic      [DIR_WIDTH-1:0]      dir,
	output logic      [DELTA_WIDTH-1:0]    mag
);

	logic                      up;
	logic [POSITION_WIDTH-1:0] span;

	assign up   = cur > prev;
	assign span = up ? (cur - prev) : (prev - cur);

	always_comb begin
		if (cur == prev) begin
			dir = DIR_NONE;
			mag = '0;
		end else begin
			dir = up ? DIR_UP : DIR_DOWN;
			if (span > POSITION_WIDTH'(DELTA_LIMIT)) begin
				mag = DELTA_WIDTH'(DELTA_LIMIT);
			end else begin
				mag = span[DELTA_WIDTH-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ttrm_motion.sv
// touch mode tracking, stored position and report generation
`default_nettype none
module ttrm_motion
	import ttrm_pkg::*;
#(
	parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      step,
	input  wire logic [POSITION_WIDTH-1:0] x_pos,
	input  wire logic [POSITION_WIDTH-1:0] y_pos,
	input  wire logic                      btn,
	input  wire logic [POSITION_WIDTH-1:0] x_min,
	input  wire logic [POSITION_WIDTH-1:0] y_min,
	output logic                           res_valid,
	output report_t                        rpt
);

	logic [MODE_WIDTH-1:0]     mode_q, mode_d;
	logic [POSITION_WIDTH-1:0] last_x_q, last_y_q;
	logic                      store;
	logic                      touch_on, touch_off;
	logic [DIR_WIDTH-1:0]      x_dir, y_dir;
	logic [DELTA_WIDTH-1:0]    x_mag, y_mag;

	ttrm_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_axis_x (
		.cur(x_pos), .prev(last_x_q), .dir(x_dir), .mag(x_mag)
	);
	ttrm_axis #(.POSITION_WIDTH(POSITION_WIDTH)) u_axis_y (
		.cur(y_pos), .prev(last_y_q), .dir(y_dir), .mag(y_mag)
	);

	assign touch_on  = ((x_pos >= x_min) && (y_pos >= y_min)) || btn;
	assign touch_off = (x_pos < x_min) && (y_pos < y_min) && !btn;

	always_comb begin
		mode_d    = mode_q;
		store     = 1'b0;
		res_valid = 1'b0;
		rpt       = '0;
		case (mode_q)
			MODE_IDLE: begin
				if (touch_on) begin
					store  = 1'b1;
					mode_d = MODE_TOUCHING;
				end
			end
			MODE_TOUCHING: begin
				if (touch_off) begin
					mode_d = MODE_RELEASED;
				end else begin
					store           = 1'b1;
					res_valid       = 1'b1;
					rpt.button      = btn;
					rpt.x_direction = x_dir;
					rpt.x_delta     = x_mag;
					rpt.y_direction = y_dir;
					rpt.y_delta     = y_mag;
				end
			end
			MODE_RELEASED: begin
				// release report is all zero
				res_valid = 1'b1;
				mode_d    = MODE_IDLE;
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			if (store) begin
				last_x_q <= x_pos;
				last_y_q <= y_pos;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/touch_to_relative_motion_top.sv
// top level: absolute touchpad samples in, relative motion reports out
//
// input channel: one word per touchpad sample (x_position, y_position,
// left_button), taken at a clock edge with in_valid high and in_stall low.
// output channel: one word per report (button, direction and saturated
// delta per axis), taken at an edge with out_valid high and out_stall low.
// configuration channel: cfg_index selects x_touch_min (0) or y_touch_min
// (1), cfg_data is the new threshold; cfg_ready is always high and writes
// to other indexes are dropped. write thresholds only while no word is in
// flight.
// a sample lands in an input register, the mode logic and the two axis
// units work on it combinationally, and the report goes into the output
// register, which drives out_valid.
// one sample per cycle is sustained while out_stall is low; a sample that
// makes no report (touch start, touch end) simply uses up its cycle.
// reset clears the mode to idle, the stored position to zero and the
// thresholds to 1200; both pipeline registers come up empty.
// while the receiver stalls, the report holds in the output register and
// one more sample can wait in the input register; only then is in_stall
// raised, combinationally from out_stall.
`default_nettype none
module touch_to_relative_motion_top
	import ttrm_pkg::*;
#(
	parameter int POSITION_WIDTH = DEFAULT_POSITION_WIDTH
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// sample word
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [POSITION_WIDTH-1:0]  x_position,
	input  wire logic [POSITION_WIDTH-1:0]  y_position,
	input  wire logic                       left_button,
	// report word
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            button,
	output logic      [DIR_WIDTH-1:0]       x_direction,
	output logic      [DELTA_WIDTH-1:0]     x_delta,
	output logic      [DIR_WIDTH-1:0]       y_direction,
	output logic      [DELTA_WIDTH-1:0]     y_delta,
	// threshold writes
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [POSITION_WIDTH-1:0]  cfg_data
);

	// threshold registers
	logic [POSITION_WIDTH-1:0] x_min_q, y_min_q;

	// input stage
	logic                      valid_s1;
	logic [POSITION_WIDTH-1:0] x_s1, y_s1;
	logic                      btn_s1;

	// output stage
	logic    valid_s2;
	report_t rpt_s2;

	logic    in_take;
	logic    advance;
	logic    res_valid;
	report_t rpt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= POSITION_WIDTH'(TOUCH_MIN_RESET);
			y_min_q <= POSITION_WIDTH'(TOUCH_MIN_RESET);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_TOUCH_MIN: x_min_q <= cfg_data;
				REG_Y_TOUCH_MIN: y_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// the stage-1 sample is processed whenever the output register is free
	// or being emptied at this edge
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			x_s1   <= x_position;
			y_s1   <= y_position;
			btn_s1 <= left_button;
		end
	end

	ttrm_motion #(.POSITION_WIDTH(POSITION_WIDTH)) u_motion (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.x_pos     (x_s1),
		.y_pos     (y_s1),
		.btn       (btn_s1),
		.x_min     (x_min_q),
		.y_min     (y_min_q),
		.res_valid (res_valid),
		.rpt       (rpt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res_valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			rpt_s2 <= rpt;
		end
	end

	assign out_valid   = valid_s2;
	assign button      = rpt_s2.button;
	assign x_direction = rpt_s2.x_direction;
	assign x_delta     = rpt_s2.x_delta;
	assign y_direction = rpt_s2.y_direction;
	assign y_delta     = rpt_s2.y_delta;

endmodule
`default_nettype wire

// File: sv/ttrm_checker.sv
// port-level checks of the touch to relative motion block, bound to the top
`default_nettype none
module ttrm_checker
	import ttrm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_stall,
	input wire logic                   out_valid,
	input wire logic                   out_stall,
	input wire logic                   button,
	input wire logic [DIR_WIDTH-1:0]   x_direction,
	input wire logic [DELTA_WIDTH-1:0] x_delta,
	input wire logic [DIR_WIDTH-1:0]   y_direction,
	input wire logic [DELTA_WIDTH-1:0] y_delta
);

	// a stalled report holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(button)
			&& $stable(x_direction) && $stable(x_delta)
			&& $stable(y_direction) && $stable(y_delta))
		else $error("stalled report changed");

	// input backs up only behind a stalled report
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

	// a fresh report follows a sample taken through the input and output registers
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("report without matching sample");

	// no motion means zero magnitude, motion means nonzero magnitude
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((x_direction == DIR_NONE) == (x_delta == '0))
			&& ((y_direction == DIR_NONE) == (y_delta == '0)))
		else $error("direction and delta disagree");

	// direction codes stay within none, up and down
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_direction == DIR_NONE || x_direction == DIR_UP
			|| x_direction == DIR_DOWN) && (y_direction == DIR_NONE
			|| y_direction == DIR_UP || y_direction == DIR_DOWN))
		else $error("bad direction code");

endmodule

bind touch_to_relative_motion_top ttrm_checker u_ttrm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.button      (button),
	.x_direction (x_direction),
	.x_delta     (x_delta),
	.y_direction (y_direction),
	.y_delta     (y_delta)
);
`default_nettype wire

// File: verif/ttrm_tb_pkg.sv
`timescale 1ns / 1ps
// report tracker for the touch to relative motion testbench
package ttrm_tb_pkg;
	import ttrm_pkg::*;

	// register indexes that the block must ignore
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 2'd3;

	class touch_report_tracker;
		logic [15:0]           x_min;
		logic [15:0]           y_min;
		logic [MODE_WIDTH-1:0] mode;
		logic [15:0]           last_x;
		logic [15:0]           last_y;
		report_t               pending_reports[$];
		int unsigned           mismatches;
		int unsigned           samples_seen;
		int unsigned           reports_seen;

		function new();
			x_min        = 16'(TOUCH_MIN_RESET);
			y_min        = 16'(TOUCH_MIN_RESET);
			mode         = MODE_IDLE;
			last_x       = '0;
			last_y       = '0;
			mismatches   = 0;
			samples_seen = 0;
			reports_seen = 0;
		endfunction

		function void set_threshold(logic [CFG_INDEX_WIDTH-1:0] idx, logic [15:0] value);
			case (idx)
				REG_X_TOUCH_MIN: x_min = value;
				REG_Y_TOUCH_MIN: y_min = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return pending_reports.size();
		endfunction

		function void axis_motion(input logic [15:0] cur, input logic [15:0] prev,
				output logic [DIR_WIDTH-1:0] dir, output logic [DELTA_WIDTH-1:0] mag);
			int unsigned span;
			if (cur == prev) begin
				dir  = DIR_NONE;
				span = 0;
			end else if (cur > prev) begin
				dir  = DIR_UP;
				span = 32'(cur) - 32'(prev);
			end else begin
				dir  = DIR_DOWN;
				span = 32'(prev) - 32'(cur);
			end
			mag = (span > DELTA_LIMIT) ? DELTA_LIMIT[DELTA_WIDTH-1:0] : span[DELTA_WIDTH-1:0];
		endfunction

		// accepted sample: advance the mode and queue the report it causes
		function void note_sample(logic [15:0] x, logic [15:0] y, logic b);
			report_t rep;
			samples_seen++;
			case (mode)
				MODE_IDLE: begin
					if ((x >= x_min && y >= y_min) || b) begin
						last_x = x;
						last_y = y;
						mode   = MODE_TOUCHING;
					end
				end
				MODE_TOUCHING: begin
					if (x < x_min && y < y_min && !b) begin
						mode = MODE_RELEASED;
					end else begin
						rep.button = b;
						axis_motion(x, last_x, rep.x_direction, rep.x_delta);
						axis_motion(y, last_y, rep.y_direction, rep.y_delta);
						pending_reports.push_back(rep);
						last_x = x;
						last_y = y;
					end
				end
				MODE_RELEASED: begin
					rep = '0;
					pending_reports.push_back(rep);
					mode = MODE_IDLE;
				end
				default: mode = MODE_IDLE;
			endcase
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(report_t got);
			report_t want;
			reports_seen++;
			if (pending_reports.size() == 0) begin
				$display("%0t: report with none expected, expected nothing, actual %h",
					$time, got);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("button", 8'(want.button), 8'(got.button));
			compare_field("x_direction", 8'(want.x_direction), 8'(got.x_direction));
			compare_field("x_delta", want.x_delta, got.x_delta);
			compare_field("y_direction", 8'(want.y_direction), 8'(got.y_direction));
			compare_field("y_delta", want.y_delta, got.y_delta);
		endfunction
	endclass

endpackage

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench top: drives touchpad samples and threshold writes, checks every report
module tb_top;
	import ttrm_pkg::*;
	import ttrm_tb_pkg::*;

	localparam int PW = DEFAULT_POSITION_WIDTH;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic [PW-1:0]              x_position  = '0;
	logic [PW-1:0]              y_position  = '0;
	logic                       left_button = 1'b0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic                       button;
	logic [DIR_WIDTH-1:0]       x_direction;
	logic [DELTA_WIDTH-1:0]     x_delta;
	logic [DIR_WIDTH-1:0]       y_direction;
	logic [DELTA_WIDTH-1:0]     y_delta;
	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
	logic [PW-1:0]              cfg_data    = '0;

	// idle and stall bursts allowed on both sides while set
	bit                  idle_bursts = 1'b1;
	int unsigned         cfg_writes  = 0;
	touch_report_tracker tracker     = new();

	always #2 clk = ~clk;

	touch_to_relative_motion_top #(
		.POSITION_WIDTH(PW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.x_position(x_position),
		.y_position(y_position),
		.left_button(left_button),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.button(button),
		.x_direction(x_direction),
		.x_delta(x_delta),
		.y_direction(y_direction),
		.y_delta(y_delta),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// report word taken at this edge goes straight to the tracker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_report({button, x_direction, x_delta, y_direction, y_delta});
	end

	// receiver side: random stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idle_bursts && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// one sample word; holds until taken, then maybe idles the sender
	task automatic send_sample(input logic [PW-1:0] x, input logic [PW-1:0] y, input logic b);
		in_valid    <= 1'b1;
		x_position  <= x;
		y_position  <= y;
		left_button <= b;
		do @(posedge clk); while (in_stall);
		tracker.note_sample(x, y, b);
		if (idle_bursts && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// caller lowers cfg_valid after the last write of a batch
	task automatic write_threshold(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [PW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_threshold(idx, value);
		cfg_writes++;
	endtask

	// sender pauses until every expected report is back, then lets the pipe settle
	task automatic drain_reports(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (settle) @(posedge clk);
	endtask

	// random walk step: mostly small, sometimes none, sometimes past saturation
	function automatic logic [PW-1:0] nudge(input logic [PW-1:0] p);
		int step;
		int n;
		case ($urandom_range(0, 9))
			0: step = 0;
			1: step = $urandom_range(200, 700);
			default: step = $urandom_range(1, 40);
		endcase
		if ($urandom_range(0, 1))
			step = -step;
		n = int'(p) + step;
		if (n < 0)
			n = 0;
		else if (n > 65535)
			n = 65535;
		return n[PW-1:0];
	endfunction

	// touch down, a drag, usually lift off and the trailing sample; now and then plain noise
	task automatic run_gesture();
		logic [PW-1:0] x;
		logic [PW-1:0] y;
		logic          b;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4))
				send_sample(PW'($urandom_range(0, 65535)), PW'($urandom_range(0, 65535)),
					1'($urandom_range(0, 1)));
			return;
		end
		b = 1'($urandom_range(0, 1));
		if (b) begin
			x = PW'($urandom_range(0, 65535));
			y = PW'($urandom_range(0, 65535));
		end else begin
			x = PW'($urandom_range(tracker.x_min, 65535));
			y = PW'($urandom_range(tracker.y_min, 65535));
		end
		send_sample(x, y, b);
		repeat ($urandom_range(1, 12)) begin
			x = nudge(x);
			y = nudge(y);
			if ($urandom_range(0, 3) == 0)
				b = ~b;
			send_sample(x, y, b);
		end
		// lift off only exists when both thresholds are above zero
		if (tracker.x_min != 0 && tracker.y_min != 0 && $urandom_range(0, 5) != 0) begin
			send_sample(PW'($urandom_range(0, tracker.x_min - 1)),
				PW'($urandom_range(0, tracker.y_min - 1)), 1'b0);
			send_sample(PW'($urandom_range(0, 65535)), PW'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int unsigned   target;
		bit            held;
		logic [PW-1:0] xm;
		logic [PW-1:0] ym;
		held = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset thresholds of 1200
		send_sample(16'd1199, 16'd1199, 1'b0);   // both just below, stays idle
		send_sample(16'd1200, 16'd0, 1'b0);      // only x at threshold, stays idle
		send_sample(16'd0, 16'd1200, 1'b0);      // only y at threshold, stays idle
		send_sample(16'd1200, 16'd1200, 1'b0);   // touch down exactly at threshold
		send_sample(16'd1200, 16'd1200, 1'b0);   // no motion on either axis
		send_sample(16'd65535, 16'd0, 1'b1);     // both axes saturate, opposite ways
		send_sample(16'd65435, 16'd10, 1'b1);    // y below threshold but button held
		send_sample(16'd65435, 16'd10, 1'b0);    // x alone keeps the touch
		send_sample(16'd0, 16'd0, 1'b0);         // lift off
		send_sample(16'd65535, 16'd65535, 1'b1); // released: all-zero report regardless
		send_sample(16'd0, 16'd0, 1'b1);         // touch down by button only
		send_sample(16'd255, 16'd256, 1'b1);     // delta exactly 255 and one past
		send_sample(16'd1, 16'd2, 1'b1);         // decreasing by 254
		send_sample(16'd1199, 16'd1199, 1'b0);   // lift off on the boundary
		send_sample(16'd1, 16'd1, 1'b1);         // released report ignores the button
		send_sample(16'd1200, 16'd1199, 1'b0);   // y one short, stays idle
		send_sample(16'd1200, 16'd1200, 1'b1);   // touch down
		send_sample(16'd1199, 16'd2000, 1'b0);   // x below, y above: still a report

		// random phases, each with its own threshold setting
		for (int ph = 0; ph < 9; ph++) begin
			drain_reports(4);
			// quiet stretch every third phase and for the whole last phase
			idle_bursts = (ph % 3 != 2) && (ph != 8);
			write_threshold((ph % 2) ? REG_SPARE_HI : REG_SPARE_LO,
				PW'($urandom_range(0, 65535)));
			case (ph)
				0: begin xm = 16'd0;     ym = 16'd0;     end
				1: begin xm = 16'd65535; ym = 16'd65535; end
				2: begin xm = 16'd65535; ym = 16'd0;     end
				3: begin xm = 16'd0;     ym = 16'd65535; end
				8: begin xm = 16'd1;     ym = 16'd1;     end
				default: begin
					xm = PW'($urandom_range(0, 65535));
					ym = PW'($urandom_range(0, 65535));
				end
			endcase
			write_threshold(REG_X_TOUCH_MIN, xm);
			write_threshold(REG_Y_TOUCH_MIN, ym);
			cfg_valid <= 1'b0;
			target = tracker.samples_seen + 75;
			while (tracker.samples_seen < target) begin
				run_gesture();
				// mid-phase hold until the receiver has caught up
				if (ph == 4 && !held && tracker.samples_seen + 40 > target) begin
					drain_reports(0);
					held = 1'b1;
				end
			end
		end

		drain_reports(10);
		$display("covered %0d samples and %0d reports over %0d threshold writes",
			tracker.samples_seen, tracker.reports_seen, cfg_writes);
		$display("thresholds went through 0, 1, 1200, 65535, random values and ignored indexes");
		if (tracker.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
